### design/fifo_and_max_dual_service_queue_unit_macros.svh
// assertion macros for the dual service queue
`ifndef FIFO_AND_MAX_DUAL_SERVICE_QUEUE_UNIT_MACROS_SVH
`define FIFO_AND_MAX_DUAL_SERVICE_QUEUE_UNIT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define FMQ_CHECK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define FMQ_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fmq_pkg.sv
// shared types and constants for the dual service queue
package fmq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VAL_W    = 24;
    localparam int NUM_W    = 32;

    typedef enum logic [1:0] {
        CMD_ARRIVE  = 2'd0,
        CMD_OLDEST  = 2'd1,
        CMD_LARGEST = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_SERVED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_TRIM
    } t_state;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [VAL_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [NUM_W-1:0] served_number;
        logic [1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic             span;
        logic [VAL_W-1:0] value;
        logic [NUM_W-1:0] number;
    } t_slot;

    typedef struct packed {
        logic             wave;
        logic             found;
        logic [VAL_W-1:0] value;
        logic [NUM_W-1:0] number;
        logic [IDX_W-1:0] index;
    } t_carry;

    typedef struct packed {
        logic             arrive;
        logic             shift;
        logic             drop_tail;
        logic             remove;
        logic [IDX_W-1:0] remove_idx;
        logic             scan_start;
        logic [VAL_W-1:0] value;
        logic [NUM_W-1:0] number;
    } t_cell_ctl;

endpackage

### design/fmq_cell.sv
// one queue cell: slot storage, shift to neighbour and running-maximum stage
module fmq_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [fmq_pkg::IDX_W-1:0] i_idx,
    input  fmq_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_prev_span,
    input  fmq_pkg::t_slot           i_next,
    input  fmq_pkg::t_carry          i_car,
    output fmq_pkg::t_slot           o_slot,
    output fmq_pkg::t_carry          o_car,
    output logic                     o_tail_hole
);

    logic                      r_valid;
    logic                      r_span;
    logic [fmq_pkg::VAL_W-1:0] r_value;
    logic [fmq_pkg::NUM_W-1:0] r_number;
    logic                      n_valid;
    logic                      n_span;
    logic [fmq_pkg::VAL_W-1:0] n_value;
    logic [fmq_pkg::NUM_W-1:0] n_number;
    fmq_pkg::t_carry           r_car;
    fmq_pkg::t_carry           n_car;
    logic                      w_hit;
    logic                      w_take;

    assign w_hit       = i_ctl.remove && (i_ctl.remove_idx == i_idx);
    assign o_tail_hole = r_span && !i_next.span && !r_valid;
    assign w_take      = r_valid && (!i_car.found || (r_value > i_car.value));

    always_comb begin
        n_valid  = r_valid;
        n_span   = r_span;
        n_value  = r_value;
        n_number = r_number;
        priority if (i_ctl.shift) begin
            n_valid  = i_next.valid;
            n_span   = i_next.span;
            n_value  = i_next.value;
            n_number = i_next.number;
        end else if (i_ctl.arrive && i_prev_span && !r_span) begin
            n_valid  = 1'b1;
            n_span   = 1'b1;
            n_value  = i_ctl.value;
            n_number = i_ctl.number;
        end else if (w_hit) begin
            n_valid = 1'b0;
        end else if (i_ctl.drop_tail && o_tail_hole) begin
            n_span = 1'b0;
        end else begin
        end
    end

    always_comb begin
        n_car = i_car;
        if (w_take) begin
            n_car.found  = 1'b1;
            n_car.value  = r_value;
            n_car.number = r_number;
            n_car.index  = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_span     <= 1'b0;
            r_car.wave <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_span  <= n_span;
            r_car   <= n_car;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_number <= n_number;
    end

    assign o_slot = '{valid: r_valid, span: r_span, value: r_value, number: r_number};
    assign o_car  = r_car;

endmodule

### design/fifo_and_max_dual_service_queue_unit.sv
// top level of the dual service queue: control sequencer and row of cells
//
// input channel: i_in_valid / o_in_stall carry one command transaction
// (arrive, serve oldest, serve largest). output channel: o_out_valid /
// i_out_stall carry one result transaction (served number and status).
// an arrival that fits, or a none command, gives no result; any other command gives one.
// an arrival into a full span, a serve from an empty store and serve oldest
// load their result into the output register at acceptance; it shows in the next cycle.
// serve largest runs a maximum wave through the row of CAPACITY cells, each
// with a registered carry stage; the winner is removed and its result registered
// once the output register is free. after each removal the span is trimmed,
// one emptied end slot per cycle, until none is left; the next command waits for that.
// results sit in an output register; a stalled receiver holds them, and a
// new command is taken only while that register is free or being emptied.
// reset empties the store and restarts arrival numbers at one.

`include "fifo_and_max_dual_service_queue_unit_macros.svh"

module fifo_and_max_dual_service_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fmq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fmq_pkg::t_out_item o_out_data
);

    fmq_pkg::t_state           r_state;
    fmq_pkg::t_state           n_state;
    logic [fmq_pkg::NUM_W-1:0] r_next_num;
    logic [fmq_pkg::NUM_W-1:0] r_pick_num;
    logic [fmq_pkg::IDX_W-1:0] r_pick_idx;
    logic                      r_out_valid;
    fmq_pkg::t_out_item        r_out;

    fmq_pkg::t_cell_ctl        w_ctl;
    fmq_pkg::t_slot            w_slot [fmq_pkg::CAPACITY];
    fmq_pkg::t_carry           w_car  [fmq_pkg::CAPACITY];
    fmq_pkg::t_carry           w_car0;
    fmq_pkg::t_carry           w_last_car;
    logic [fmq_pkg::CAPACITY-1:0] w_hole;
    logic                      w_any_hole;
    logic                      w_out_free;
    logic                      w_accept;
    logic                      w_load;
    fmq_pkg::t_out_item        w_load_data;
    logic                      w_num_inc;
    logic                      w_front_hole;
    logic                      w_wave_out;
    logic                      w_idle;
    logic                      w_scan;
    logic                      w_serve_head;

    assign w_idle       = (r_state == fmq_pkg::S_IDLE);
    assign w_scan       = (r_state == fmq_pkg::S_SCAN);
    assign w_any_hole   = |w_hole;
    assign w_front_hole = w_slot[0].span && !w_slot[0].valid;
    assign w_last_car   = w_car[fmq_pkg::CAPACITY-1];
    assign w_wave_out   = w_last_car.wave;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall   = !(w_idle && w_out_free);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_serve_head = w_idle && w_accept && (i_in_data.cmd == fmq_pkg::CMD_OLDEST)
                          && w_slot[0].span;

    always_comb begin
        w_car0       = '0;
        w_car0.wave  = w_ctl.scan_start;
    end

    generate
        for (genvar g = 0; g < fmq_pkg::CAPACITY; g++) begin : g_cell
            logic            w_prev_span;
            fmq_pkg::t_slot  w_next;
            fmq_pkg::t_carry w_car_in;

            if (g == 0) begin : g_first
                assign w_prev_span = 1'b1;
                assign w_car_in    = w_car0;
            end else begin : g_mid
                assign w_prev_span = w_slot[g-1].span;
                assign w_car_in    = w_car[g-1];
            end

            if (g == fmq_pkg::CAPACITY - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_slot[g+1];
            end

            fmq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_idx       (fmq_pkg::IDX_W'(g)),
                .i_ctl       (w_ctl),
                .i_prev_span (w_prev_span),
                .i_next      (w_next),
                .i_car       (w_car_in),
                .o_slot      (w_slot[g]),
                .o_car       (w_car[g]),
                .o_tail_hole (w_hole[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fmq_pkg::S_IDLE: begin
                if (w_accept && w_slot[0].span) begin
                    if (i_in_data.cmd == fmq_pkg::CMD_OLDEST) begin
                        n_state = fmq_pkg::S_TRIM;
                    end else if (i_in_data.cmd == fmq_pkg::CMD_LARGEST) begin
                        n_state = fmq_pkg::S_SCAN;
                    end
                end
            end
            fmq_pkg::S_SCAN: begin
                if (w_wave_out) begin
                    n_state = fmq_pkg::S_REMOVE;
                end
            end
            fmq_pkg::S_REMOVE: begin
                if (w_out_free) begin
                    n_state = fmq_pkg::S_TRIM;
                end
            end
            fmq_pkg::S_TRIM: begin
                if (!w_front_hole && !w_any_hole) begin
                    n_state = fmq_pkg::S_IDLE;
                end
            end
            default: n_state = fmq_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ctl        = '0;
        w_ctl.value  = i_in_data.amount;
        w_ctl.number = r_next_num;
        w_load       = 1'b0;
        w_load_data  = '{served_number: '0, status: fmq_pkg::ST_SERVED};
        w_num_inc    = 1'b0;
        unique case (r_state)
            fmq_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_data.cmd)
                        fmq_pkg::CMD_ARRIVE: begin
                            if (w_slot[fmq_pkg::CAPACITY-1].span) begin
                                w_load             = 1'b1;
                                w_load_data.status = fmq_pkg::ST_FULL;
                            end else begin
                                w_ctl.arrive = 1'b1;
                                w_num_inc    = 1'b1;
                            end
                        end
                        fmq_pkg::CMD_OLDEST: begin
                            w_load = 1'b1;
                            if (!w_slot[0].span) begin
                                w_load_data.status = fmq_pkg::ST_EMPTY;
                            end else begin
                                w_load_data.served_number = w_slot[0].number;
                                w_ctl.remove              = 1'b1;
                            end
                        end
                        fmq_pkg::CMD_LARGEST: begin
                            if (!w_slot[0].span) begin
                                w_load             = 1'b1;
                                w_load_data.status = fmq_pkg::ST_EMPTY;
                            end else begin
                                w_ctl.scan_start = 1'b1;
                            end
                        end
                        fmq_pkg::CMD_NONE: begin
                        end
                    endcase
                end
            end
            fmq_pkg::S_SCAN: begin
            end
            fmq_pkg::S_REMOVE: begin
                if (w_out_free) begin
                    w_load                    = 1'b1;
                    w_load_data.served_number = r_pick_num;
                    w_ctl.remove              = 1'b1;
                    w_ctl.remove_idx          = r_pick_idx;
                end
            end
            fmq_pkg::S_TRIM: begin
                if (w_front_hole) begin
                    w_ctl.shift = 1'b1;
                end else if (w_any_hole) begin
                    w_ctl.drop_tail = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmq_pkg::S_IDLE;
            r_next_num  <= fmq_pkg::NUM_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_num_inc) begin
                r_next_num <= r_next_num + fmq_pkg::NUM_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_load_data;
        end
        if (w_scan && w_wave_out) begin
            r_pick_num <= w_last_car.number;
            r_pick_idx <= w_last_car.index;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `FMQ_CHECK(a_head_valid, (w_idle && w_slot[0].span) |-> w_slot[0].valid, "idle head empty")
    `FMQ_CHECK(a_tail_trimmed, w_idle |-> !w_any_hole, "newest slot of span empty when idle")
    `FMQ_CHECK(a_wave_found, w_wave_out |-> (w_last_car.found && w_scan), "wave ended empty")
    `FMQ_CHECK(a_no_overwrite, w_load |-> w_out_free, "result register loaded while held")
    `FMQ_CHECK_NEXT(a_removed_gone, w_serve_head, !w_slot[0].valid, "served head still valid")

endmodule

### bench/testbench.sv
// self-checking testbench for the dual service queue: directed table, random traffic, predictor
module testbench;

    localparam int RANDOM_PER_PHASE = 105;
    localparam int SEGMENT_LEN      = 35;
    localparam int TAIL_CYCLES      = 2 * fmq_pkg::CAPACITY + 8;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef struct packed {
        fmq_pkg::t_cmd             cmd;
        logic [fmq_pkg::VAL_W-1:0] amount;
        logic [7:0]                reps;
        bit                        typed;
        logic [fmq_pkg::NUM_W-1:0] number;
        fmq_pkg::t_status          status;
    } t_script_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    fmq_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    fmq_pkg::t_out_item o_out_data;

    // shadow copy of the store
    logic [fmq_pkg::VAL_W-1:0] slot_amount [fmq_pkg::CAPACITY];
    logic [fmq_pkg::NUM_W-1:0] slot_tag [fmq_pkg::CAPACITY];
    bit                        slot_busy [fmq_pkg::CAPACITY];
    int                        head_slot = 0;
    int                        span_len = 0;
    logic [fmq_pkg::NUM_W-1:0] next_tag = 1;

    t_script_row        script_rows [$];
    fmq_pkg::t_out_item pending_services [$];
    int                 mismatch_count = 0;
    int                 sender_idle_pct = 0;
    int                 stall_pct = 0;
    int unsigned        cycle_count = 0;

    fifo_and_max_dual_service_queue_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit predict_service(input fmq_pkg::t_in_item item,
                                           output fmq_pkg::t_out_item res);
        int pick;
        int k;
        int p;
        res = '0;
        case (item.cmd)
            fmq_pkg::CMD_ARRIVE: begin
                if (span_len >= fmq_pkg::CAPACITY) begin
                    res.status = fmq_pkg::ST_FULL;
                    return 1'b1;
                end
                p = (head_slot + span_len) % fmq_pkg::CAPACITY;
                slot_amount[p] = item.amount;
                slot_tag[p]    = next_tag;
                slot_busy[p]   = 1'b1;
                span_len++;
                next_tag = next_tag + 1'b1;
                return 1'b0;
            end
            fmq_pkg::CMD_NONE: return 1'b0;
            default: begin
                if (span_len == 0) begin
                    res.status = fmq_pkg::ST_EMPTY;
                    return 1'b1;
                end
                pick = head_slot;
                if (item.cmd == fmq_pkg::CMD_LARGEST) begin
                    for (k = 1; k < span_len; k++) begin
                        p = (head_slot + k) % fmq_pkg::CAPACITY;
                        if (slot_busy[p] && slot_amount[p] > slot_amount[pick])
                            pick = p;
                    end
                end
                res.served_number = slot_tag[pick];
                res.status        = fmq_pkg::ST_SERVED;
                slot_busy[pick]   = 1'b0;
                // trim emptied slots at both ends of the span
                while (span_len > 0 && !slot_busy[head_slot]) begin
                    head_slot = (head_slot + 1) % fmq_pkg::CAPACITY;
                    span_len--;
                end
                while (span_len > 0
                       && !slot_busy[(head_slot + span_len - 1) % fmq_pkg::CAPACITY])
                    span_len--;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void add_row(input fmq_pkg::t_cmd cmd,
                                    input logic [fmq_pkg::VAL_W-1:0] amount,
                                    input int reps, input bit typed,
                                    input logic [fmq_pkg::NUM_W-1:0] number,
                                    input fmq_pkg::t_status status);
        t_script_row row;
        row.cmd    = cmd;
        row.amount = amount;
        row.reps   = 8'(reps);
        row.typed  = typed;
        row.number = number;
        row.status = status;
        script_rows.insert(script_rows.size(), row);
    endfunction

    function automatic void expect_result(input fmq_pkg::t_out_item res);
        pending_services.insert(pending_services.size(), res);
    endfunction

    // returns at the edge where the transaction is taken
    task automatic send_command(input fmq_pkg::t_in_item item);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic await_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_services.size() != 0);
    endtask

    function automatic fmq_pkg::t_in_item random_command(input int arrive_bias);
        fmq_pkg::t_in_item item;
        if ($urandom_range(0, 99) < 4)
            item.cmd = fmq_pkg::CMD_NONE;
        else if ($urandom_range(0, 99) < arrive_bias)
            item.cmd = fmq_pkg::CMD_ARRIVE;
        else
            item.cmd = $urandom_range(0, 1) ? fmq_pkg::CMD_OLDEST : fmq_pkg::CMD_LARGEST;
        case ($urandom_range(0, 3))
            0: item.amount = fmq_pkg::VAL_W'($urandom_range(0, 3));
            1: item.amount = $urandom_range(0, 1) ? {fmq_pkg::VAL_W{1'b1}}
                                                  : {fmq_pkg::VAL_W{1'b0}};
            default: item.amount = fmq_pkg::VAL_W'($urandom());
        endcase
        return item;
    endfunction

    // result side: check and stall
    always @(posedge i_clk) begin : result_side
        fmq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_services.size() == 0) begin
                $display("%0t unexpected result: expected none, actual number %0d status %0d",
                         $time, o_out_data.served_number, o_out_data.status);
                mismatch_count++;
            end else begin
                want = pending_services.pop_front();
                if (o_out_data.served_number !== want.served_number) begin
                    $display("%0t served_number mismatch: expected %0d, actual %0d",
                             $time, want.served_number, o_out_data.served_number);
                    mismatch_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_out_data.status);
                    mismatch_count++;
                end
            end
        end
        i_out_stall <= stall_pct != 0 && $urandom_range(0, 99) < stall_pct;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fifo_and_max_dual_service_queue_unit verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        fmq_pkg::t_in_item  item;
        fmq_pkg::t_out_item predicted;
        fmq_pkg::t_out_item typed;
        int                 r;
        int                 n;
        int                 phase;
        int                 sent;
        int                 arrive_bias;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;

        // empty store, basic ordering, full ring with and without holes
        add_row(fmq_pkg::CMD_OLDEST,  24'h000000,  1, 1'b1, 0,  fmq_pkg::ST_EMPTY);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000,  1, 1'b1, 0,  fmq_pkg::ST_EMPTY);
        add_row(fmq_pkg::CMD_NONE,    24'hFFFFFF,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h000000,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'hFFFFFF,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h800000,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000,  1, 1'b1, 2,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_OLDEST,  24'hFFFFFF,  1, 1'b1, 1,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000,  1, 1'b1, 3,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_OLDEST,  24'h000000,  1, 1'b1, 0,  fmq_pkg::ST_EMPTY);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h5A5A5A, 64, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h123456,  1, 1'b1, 0,  fmq_pkg::ST_FULL);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000,  1, 1'b1, 4,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'hFFFFFF,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h000000,  1, 1'b1, 0,  fmq_pkg::ST_FULL);
        add_row(fmq_pkg::CMD_NONE,    24'hAAAAAA,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000,  1, 1'b1, 68, fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_OLDEST,  24'h000000, 63, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000,  1, 1'b1, 0,  fmq_pkg::ST_EMPTY);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h000001, 32, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'hFFFFFF,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h000001, 31, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'h000000,  1, 1'b1, 0,  fmq_pkg::ST_FULL);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000,  1, 1'b0, 0,  fmq_pkg::ST_SERVED);
        add_row(fmq_pkg::CMD_ARRIVE,  24'hAAAAAA,  1, 1'b1, 0,  fmq_pkg::ST_FULL);
        add_row(fmq_pkg::CMD_LARGEST, 24'h000000, 63, 1'b0, 0,  fmq_pkg::ST_SERVED);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < script_rows.size(); r++) begin
            for (n = 0; n < script_rows[r].reps; n++) begin
                item.cmd    = script_rows[r].cmd;
                item.amount = script_rows[r].amount;
                send_command(item);
                typed.served_number = script_rows[r].number;
                typed.status        = script_rows[r].status;
                if (predict_service(item, predicted))
                    expect_result(script_rows[r].typed ? typed : predicted);
            end
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 47; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 47; end
                default: begin sender_idle_pct = 20; stall_pct = 20; end
            endcase
            sent        = 0;
            arrive_bias = 50;
            while (sent < RANDOM_PER_PHASE) begin
                // drift occupancy so the ring both fills and drains
                if (sent % SEGMENT_LEN == 0)
                    case ($urandom_range(0, 3))
                        0: arrive_bias = 25;
                        1: arrive_bias = 50;
                        2: arrive_bias = 70;
                        default: arrive_bias = 90;
                    endcase
                item = random_command(arrive_bias);
                send_command(item);
                if (predict_service(item, predicted))
                    expect_result(predicted);
                if (item.cmd != fmq_pkg::CMD_NONE)
                    sent++;
            end
            await_drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_services.size() == 0)
            $display("fifo_and_max_dual_service_queue_unit verification clean");
        else
            $display("fifo_and_max_dual_service_queue_unit verification failed");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/fmq_pkg.sv
design/fmq_cell.sv
design/fifo_and_max_dual_service_queue_unit.sv
bench/testbench.sv
